@@ hw/rtl/kway_merge_dedup_unit_defines.svh @@
// Assertion macros shared by the merge unit RTL.
`ifndef KWAY_MERGE_DEDUP_UNIT_DEFINES_SVH
`define KWAY_MERGE_DEDUP_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define KMD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define KMD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/kmd_pkg.sv @@
// Package: beat types, opcodes and constants of the merge unit.
`timescale 1ns / 1ps
package kmd_pkg;

  localparam int STREAMS_DEF = 8;

  localparam logic [1:0] OP_WORD  = 2'd0;
  localparam logic [1:0] OP_END   = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;
  localparam logic [1:0] OP_RSVD  = 2'd3;

  localparam int          APB_ADDR_W       = 3;
  localparam int          APB_DATA_W       = 32;
  localparam logic        REG_STREAM_COUNT = 1'b0;
  localparam logic [3:0]  STREAM_COUNT_RST = 4'd8;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  stream_index;
    logic [63:0] word_value;
  } item_t;

  typedef struct packed {
    logic        emit_valid;
    logic [63:0] merged_word;
    logic [2:0]  request_stream;
    logic        merge_done;
    logic        protocol_error;
  } result_t;

endpackage

@@ hw/rtl/kway_merge_dedup_unit.sv @@
// Top level of the k-way merge unit with duplicate removal.
`timescale 1ns / 1ps
`include "kway_merge_dedup_unit_defines.svh"
// Merges up to STREAMS ascending runs of 64-bit words into one strictly
// ascending stream, dropping duplicates. A start beat latches stream_count
// (0 reads as 1, values above STREAMS read as STREAMS) and the unit then asks
// for the first word or end mark of runs 0 .. count-1 in order. After that
// each item refills the run named in the last result's request_stream; the
// unit picks the lowest-index live run holding the minimum head, emits it if
// it is the first word or above the last one emitted, and asks for that run.
// Every accepted item yields exactly one result beat. Items with opcode 3,
// for a run other than the requested one, or sent while idle/finished are
// dropped with protocol_error set. Timing: one item at a time. Start, error
// and load-phase items go straight to the output hand-off. Items that
// trigger a selection wait for the minimum scan, which reads the head RAM
// one entry per cycle, skipping ended runs, before the hand-off. A
// finished result sits in the output register, so the next item can enter
// while it waits. The head RAM needs no clearing after reset; only entries
// loaded in the current merge are used.
module kway_merge_dedup_unit #(
  parameter int STREAMS = kmd_pkg::STREAMS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // item channel
  input  logic                           item_valid,
  output logic                           item_stall,
  input  kmd_pkg::item_t                 item,
  // result channel
  output logic                           result_valid,
  input  logic                           result_stall,
  output kmd_pkg::result_t               result,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [kmd_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [kmd_pkg::APB_DATA_W-1:0] pwdata,
  output logic [kmd_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  localparam int RUN_W = $clog2(STREAMS);
  localparam int CNT_W = $clog2(STREAMS + 1);
  localparam int CW    = (CNT_W > 4) ? CNT_W : 4;  // clamp compare width
  localparam int IW    = (RUN_W > 3) ? RUN_W : 3;  // run index compare width

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_PUT} state_t;

  state_t            state;
  logic [STREAMS-1:0] run_ended;
  logic [63:0]       last_emitted;
  logic              any_emitted;
  logic [CNT_W-1:0]  load_count;
  logic [CNT_W-1:0]  load_count_next;
  logic [RUN_W-1:0]  wanted_run;
  logic              finished;
  logic [CNT_W-1:0]  active_count;
  kmd_pkg::result_t  res;          // result staged for the output register
  logic              scan_start;

  logic [3:0]        stream_count;
  logic [CNT_W-1:0]  count_clamped;
  logic [CW-1:0]     count_ext;

  logic              accept;
  logic              is_start;
  logic              bad_item;
  logic              ram_we;

  logic              ram_rd_en;
  logic [RUN_W-1:0]  ram_rd_addr;
  logic [63:0]       ram_rd_data;
  logic              scan_done;
  logic              scan_found;
  logic [RUN_W-1:0]  scan_best_idx;
  logic [63:0]       scan_best_word;
  logic [CNT_W-1:0]  best_idx_cnt;
  logic              emit_new;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  kmd_apb_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .stream_count (stream_count)
  );

  // Clamp stream_count into 1 .. STREAMS; latched only on a start beat.
  assign count_ext = CW'(stream_count);
  always_comb begin
    if (stream_count == 4'd0) begin
      count_clamped = CNT_W'(1);
    end else if (count_ext > CW'(STREAMS)) begin
      count_clamped = CNT_W'(STREAMS);
    end else begin
      count_clamped = CNT_W'(stream_count);
    end
  end

  // ---------------------------------------------------------------------------
  // Item decode
  // ---------------------------------------------------------------------------
  assign item_stall      = (state != S_IDLE);
  assign accept          = item_valid && !item_stall;
  assign is_start        = (item.opcode == kmd_pkg::OP_START);
  assign bad_item        = (item.opcode == kmd_pkg::OP_RSVD) || finished ||
                           (IW'(item.stream_index) != IW'(wanted_run));
  assign load_count_next = CNT_W'(load_count + 1'b1);

  // Head words live in RAM; a valid word beat writes the requested entry.
  assign ram_we = accept && !is_start && !bad_item &&
                  (item.opcode == kmd_pkg::OP_WORD);

  kmd_ram #(
    .WIDTH (64),
    .DEPTH (STREAMS)
  ) u_heads (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wanted_run),
    .wdata (item.word_value),
    .re    (ram_rd_en),
    .raddr (ram_rd_addr),
    .rdata (ram_rd_data)
  );

  kmd_min_scan #(
    .STREAMS (STREAMS)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .start       (scan_start),
    .count       (active_count),
    .ended       (run_ended),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data),
    .done        (scan_done),
    .found       (scan_found),
    .best_idx    (scan_best_idx),
    .best_word   (scan_best_word)
  );

  assign best_idx_cnt = CNT_W'(scan_best_idx);
  assign emit_new     = !any_emitted || (scan_best_word > last_emitted);

  // ---------------------------------------------------------------------------
  // Sequencer and output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      run_ended    <= '0;
      last_emitted <= '0;
      any_emitted  <= 1'b0;
      load_count   <= '0;
      wanted_run   <= '0;
      finished     <= 1'b1;
      scan_start   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      scan_start <= 1'b0;
      // S_PUT refills the output register itself when the beat leaves
      if (result_valid && !result_stall && (state != S_PUT)) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (is_start) begin
              run_ended    <= '0;
              last_emitted <= '0;
              any_emitted  <= 1'b0;
              load_count   <= '0;
              wanted_run   <= '0;
              finished     <= 1'b0;
              active_count <= count_clamped;
              res          <= '{emit_valid: 1'b0, merged_word: '0, request_stream: 3'd0,
                                merge_done: 1'b0, protocol_error: 1'b0};
              state        <= S_PUT;
            end else if (bad_item) begin
              // dropped: repeat the current request and done status
              res   <= '{emit_valid: 1'b0, merged_word: '0,
                         request_stream: finished ? 3'd0 : 3'(wanted_run),
                         merge_done: finished, protocol_error: 1'b1};
              state <= S_PUT;
            end else begin
              run_ended[wanted_run] <= (item.opcode == kmd_pkg::OP_END);
              if (load_count < active_count) begin
                load_count <= load_count_next;
              end
              if ((load_count < active_count) && (load_count_next < active_count)) begin
                // still loading heads in run order
                wanted_run <= RUN_W'(load_count_next);
                res        <= '{emit_valid: 1'b0, merged_word: '0,
                                request_stream: 3'(load_count_next),
                                merge_done: 1'b0, protocol_error: 1'b0};
                state      <= S_PUT;
              end else begin
                scan_start <= 1'b1;
                state      <= S_SCAN;
              end
            end
          end
        end
        S_SCAN: begin
          if (scan_done) begin
            if (!scan_found) begin
              finished   <= 1'b1;
              wanted_run <= '0;
              res        <= '{emit_valid: 1'b0, merged_word: '0, request_stream: 3'd0,
                              merge_done: 1'b1, protocol_error: 1'b0};
            end else begin
              if (emit_new) begin
                last_emitted <= scan_best_word;
                any_emitted  <= 1'b1;
              end
              wanted_run <= scan_best_idx;
              res        <= '{emit_valid: emit_new,
                              merged_word: emit_new ? scan_best_word : 64'd0,
                              request_stream: 3'(scan_best_idx),
                              merge_done: 1'b0, protocol_error: 1'b0};
            end
            state <= S_PUT;
          end
        end
        S_PUT: begin
          // hand the result over once the output register is free
          if (!result_valid || !result_stall) begin
            result       <= res;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `KMD_ASSERT_IMP(a_scan_done_in_scan, scan_done, state == S_SCAN,
                  "scan done outside scan")
  `KMD_ASSERT_IMP(a_best_in_range, scan_done && scan_found,
                  best_idx_cnt < active_count, "best run out of range")
  `KMD_ASSERT_IMP(a_done_is_quiet, result_valid && result.merge_done,
                  !result.emit_valid && result.request_stream == 3'd0,
                  "done beat carries a word or request")
  `KMD_ASSERT_IMP(a_no_write_in_scan, state == S_SCAN, !ram_we,
                  "head written during scan")

endmodule

@@ hw/rtl/kmd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module kmd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = kmd_pkg::STREAMS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/kmd_apb_regs.sv @@
// APB register block: holds the stream_count register.
`timescale 1ns / 1ps
module kmd_apb_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [kmd_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [kmd_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [kmd_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  output logic [3:0]                        stream_count
);

  logic reg_hit;

  // Word-aligned decode; the top address bit selects past the register list.
  assign reg_hit = (paddr[kmd_pkg::APB_ADDR_W-1] == kmd_pkg::REG_STREAM_COUNT);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_count <= kmd_pkg::STREAM_COUNT_RST;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      stream_count <= pwdata[3:0];
    end
  end

  assign prdata = reg_hit ? {{(kmd_pkg::APB_DATA_W-4){1'b0}}, stream_count}
                          : '0;

endmodule

@@ hw/rtl/kmd_min_scan.sv @@
// Minimum search: walks the head RAM one entry a cycle, skipping ended runs.
`timescale 1ns / 1ps
`include "kway_merge_dedup_unit_defines.svh"
module kmd_min_scan #(
  parameter int STREAMS = kmd_pkg::STREAMS_DEF,
  localparam int RUN_W = $clog2(STREAMS),
  localparam int CNT_W = $clog2(STREAMS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [CNT_W-1:0]   count,
  input  logic [STREAMS-1:0] ended,
  output logic               ram_rd_en,
  output logic [RUN_W-1:0]   ram_rd_addr,
  input  logic [63:0]        ram_rd_data,
  output logic               done,
  output logic               found,
  output logic [RUN_W-1:0]   best_idx,
  output logic [63:0]        best_word
);

  logic             busy;
  logic             pend;
  logic [CNT_W-1:0] issue_idx;
  logic [RUN_W-1:0] pend_idx;
  logic             take;

  assign ram_rd_en   = busy && (issue_idx < count);
  assign ram_rd_addr = RUN_W'(issue_idx);

  // strict less-than keeps the lowest index on a tie
  assign take = pend && !ended[pend_idx] && (!found || (ram_rd_data < best_word));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      pend  <= 1'b0;
      done  <= 1'b0;
      found <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        pend      <= 1'b0;
        found     <= 1'b0;
        issue_idx <= '0;
      end else if (busy) begin
        pend <= ram_rd_en;
        if (ram_rd_en) begin
          pend_idx  <= RUN_W'(issue_idx);
          issue_idx <= CNT_W'(issue_idx + 1'b1);
        end
        if (take) begin
          found     <= 1'b1;
          best_idx  <= pend_idx;
          best_word <= ram_rd_data;
        end
        if (!pend && !ram_rd_en) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  `KMD_ASSERT_NXT(a_read_lands, ram_rd_en, pend, "read data not tracked")
  `KMD_ASSERT_IMP(a_done_idle, done, !busy && !pend, "scan done while still busy")

endmodule

@@ bench/tb_kway_merge_dedup_unit.sv @@
// Self-checking bench for the k-way merge unit with duplicate removal.
`timescale 1ns / 1ps
module tb_kway_merge_dedup_unit;
  import kmd_pkg::*;

  // Cycle ceiling; far above the slowest legal run (long gaps, long stalls).
  localparam int CYCLE_LIMIT = 1000000;
  // Accepted, non-rejected item beats to aim for before the run winds down.
  localparam int ITEM_TARGET = 1350;
  // Settle wait; the slowest item is a selection, which scans every run.
  localparam int SETTLE_CYCLES = 20;
  localparam logic [APB_ADDR_W-1:0] ADDR_STREAM_COUNT = {REG_STREAM_COUNT, 2'b00};

  // ---------------------------------------------------------------------
  // Scoreboard: predicts each result beat at item acceptance and checks
  // result beats in order against the oldest prediction.
  // ---------------------------------------------------------------------
  class merge_scoreboard;
    logic [63:0] heads [8];
    bit          drained [8];
    logic [63:0] last_out;
    bit          out_seen;
    int unsigned loaded;
    logic [2:0]  want;
    bit          idle;
    logic [3:0]  count_reg;
    int unsigned live_runs;
    result_t     due_results [$];
    int          checked;
    int          mismatches;
    int          errors_seen;

    function new();
      for (int i = 0; i < 8; i++) begin
        heads[i] = '0;
        drained[i] = 1'b0;
      end
      last_out = '0;
      out_seen = 1'b0;
      loaded = 0;
      want = '0;
      idle = 1'b1;
      count_reg = STREAM_COUNT_RST;
      live_runs = clamp_runs(count_reg);
      checked = 0;
      mismatches = 0;
      errors_seen = 0;
    endfunction

    function int unsigned clamp_runs(logic [3:0] c);
      if (c == 0) return 1;
      if (c > 8) return 8;
      return c;
    endfunction

    function void set_count(logic [3:0] v);
      count_reg = v;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // One item beat in, the one result beat it causes out; updates state.
    function result_t merge_step(item_t it);
      result_t r;
      int unsigned best;
      bit found;
      r = '0;
      if (it.opcode == OP_START) begin
        for (int i = 0; i < 8; i++) drained[i] = 1'b0;
        last_out = '0;
        out_seen = 1'b0;
        loaded = 0;
        want = '0;
        idle = 1'b0;
        live_runs = clamp_runs(count_reg);
        return r;
      end
      // reserved opcode, no merge in progress, or not the run asked for
      if (it.opcode == OP_RSVD || idle || it.stream_index != want) begin
        r.protocol_error = 1'b1;
        r.merge_done = idle;
        r.request_stream = idle ? 3'd0 : want;
        return r;
      end
      if (it.opcode == OP_WORD) begin
        heads[it.stream_index] = it.word_value;
        drained[it.stream_index] = 1'b0;
      end else begin
        drained[it.stream_index] = 1'b1;
      end
      // head loading phase: walk runs 0 .. live_runs-1
      if (loaded < live_runs) begin
        loaded++;
        if (loaded < live_runs) begin
          want = 3'(loaded);
          r.request_stream = want;
          return r;
        end
      end
      found = 1'b0;
      best = 0;
      for (int unsigned i = 0; i < live_runs; i++) begin
        if (!drained[i] && (!found || heads[i] < heads[best])) begin
          best = i;
          found = 1'b1;
        end
      end
      if (!found) begin
        idle = 1'b1;
        want = '0;
        r.merge_done = 1'b1;
        return r;
      end
      if (!out_seen || heads[best] > last_out) begin
        r.emit_valid = 1'b1;
        r.merged_word = heads[best];
        last_out = heads[best];
        out_seen = 1'b1;
      end
      want = 3'(best);
      r.request_stream = want;
      return r;
    endfunction

    // Returns 1 when the beat is predicted to be rejected.
    function bit note_item(item_t it);
      result_t r;
      r = merge_step(it);
      due_results.push_back(r);
      if (r.protocol_error) errors_seen++;
      return r.protocol_error;
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 30) $display("MISMATCH: %s", msg);
    endtask

    task check_result(result_t got);
      result_t exp;
      checked++;
      if (due_results.size() == 0) begin
        report($sformatf("result beat %0d with no prediction pending", checked));
        return;
      end
      exp = due_results.pop_front();
      if (got.emit_valid !== exp.emit_valid)
        report($sformatf("beat %0d emit_valid %b, want %b", checked,
                         got.emit_valid, exp.emit_valid));
      if (got.merged_word !== exp.merged_word)
        report($sformatf("beat %0d merged_word %h, want %h", checked,
                         got.merged_word, exp.merged_word));
      if (got.request_stream !== exp.request_stream)
        report($sformatf("beat %0d request_stream %0d, want %0d", checked,
                         got.request_stream, exp.request_stream));
      if (got.merge_done !== exp.merge_done)
        report($sformatf("beat %0d merge_done %b, want %b", checked,
                         got.merge_done, exp.merge_done));
      if (got.protocol_error !== exp.protocol_error)
        report($sformatf("beat %0d protocol_error %b, want %b", checked,
                         got.protocol_error, exp.protocol_error));
    endtask
  endclass

  // ---------------------------------------------------------------------
  // DUT signals; every input starts at a known value.
  // ---------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  item_valid = 1'b0;
  logic                  item_stall;
  item_t                 item_beat = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result_beat;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  kway_merge_dedup_unit uut (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .item          (item_beat),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result_beat),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #4 clk = ~clk;

  merge_scoreboard sb;

  // Contents of the sorted runs fed to the current merge.
  logic [63:0] run_data [8][64];
  int          run_len [8];
  int          run_pos [8];

  int  useful_items = 0;   // accepted beats that the unit acts on
  int  sent_items = 0;
  int  merges_done = 0;
  int  config_writes = 0;
  int  hold_offs = 0;
  bit  sender_calm = 1'b0;
  int  cycle_count = 0;

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic item_t beat(logic [1:0] op, logic [2:0] idx, logic [63:0] w);
    item_t it;
    it.opcode = op;
    it.stream_index = idx;
    it.word_value = w;
    return it;
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Sender gap: mostly back to back, some short gaps, a few long ones,
  // with stretches of no gaps at all.
  function automatic int next_gap();
    int r;
    if (sent_items % 90 == 0) sender_calm = ($urandom_range(0, 2) == 0);
    if (sender_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void clear_runs();
    for (int r = 0; r < 8; r++) begin
      run_len[r] = 0;
      run_pos[r] = 0;
    end
  endfunction

  // Ascending runs. Dense mode packs ties and repeats, wide mode spreads
  // over all 64 bits, top mode crowds the all-ones word.
  function automatic void fill_runs(int mode);
    logic [63:0] w;
    logic [63:0] d;
    int n;
    for (int r = 0; r < 8; r++) begin
      n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if ($urandom_range(0, 24) == 0) n = $urandom_range(20, 40);
      run_len[r] = n;
      run_pos[r] = 0;
      case (mode)
        0: w = 64'($urandom_range(0, 4));
        1: w = rand_word() >> $urandom_range(1, 63);
        default: w = '1 - 64'($urandom_range(0, 6));
      endcase
      for (int k = 0; k < n; k++) begin
        run_data[r][k] = w;
        if (mode == 1) d = rand_word() >> $urandom_range(3, 63);
        else d = 64'($urandom_range(0, 2));
        w = (w + d < w) ? '1 : w + d;   // saturate at all-ones
      end
    end
  endfunction

  // Offer one item beat and hold it until accepted. Valid stays high after
  // acceptance; whoever waits next lowers it.
  task automatic send_item(input item_t it);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item_beat <= it;
    do @(posedge clk); while (item_stall !== 1'b0);
    if (!sb.note_item(it)) useful_items++;
    sent_items++;
  endtask

  // Register write plus readback; only once every predicted result is in.
  task automatic write_count(input logic [3:0] v);
    logic [APB_DATA_W-1:0] data;
    item_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    data = $urandom;
    data[3:0] = v;
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_STREAM_COUNT;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.set_count(v);
    config_writes++;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== {{(APB_DATA_W-4){1'b0}}, v})
      sb.report($sformatf("stream_count reads %h, want %h", prdata, v));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [3:0] pick_count();
    case ($urandom_range(0, 9))
      0: return 4'd0;                        // reads as one run
      1: return 4'd1;
      2: return 4'd8;
      3: return 4'($urandom_range(9, 15));   // reads as STREAMS
      default: return 4'($urandom_range(2, 7));
    endcase
  endfunction

  // Answer the unit's requests until the merge finishes. Some beats are
  // noise (wrong run, reserved opcode); abort_at restarts the merge early.
  task automatic drive_runs(input int noise_pct, input int abort_at);
    item_t it;
    int step;
    int r;
    step = 0;
    while (!sb.idle) begin
      if (step == abort_at) begin
        fill_runs($urandom_range(0, 2));
        it = beat(OP_START, 3'($urandom), rand_word());
      end else if ($urandom_range(0, 99) < noise_pct) begin
        if ($urandom_range(0, 1) == 0)
          it = beat(OP_RSVD, 3'($urandom), rand_word());
        else
          it = beat($urandom_range(0, 1) ? OP_WORD : OP_END,
                    sb.want + 3'($urandom_range(1, 7)), rand_word());
      end else begin
        r = sb.want;
        if (run_pos[r] < run_len[r]) begin
          it = beat(OP_WORD, 3'(r), run_data[r][run_pos[r]]);
          run_pos[r]++;
        end else begin
          it = beat(OP_END, 3'(r), rand_word());
        end
      end
      send_item(it);
      step++;
    end
  endtask

  // Beat the unit can only reject: no start, or merge already finished.
  function automatic item_t stray_beat();
    case ($urandom_range(0, 2))
      0: return beat(OP_WORD, 3'($urandom), rand_word());
      1: return beat(OP_END, 3'($urandom), rand_word());
      default: return beat(OP_RSVD, 3'($urandom), rand_word());
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Result side: check accepted beats, stall at random. Quiet stretches,
  // short and long stalls, and an occasional long hold-off so the unit
  // fills up and pushes back on the item side.
  // ---------------------------------------------------------------------
  int stall_left = 0;
  int next_hold_at = 300;
  bit recv_calm = 1'b0;
  int recv_cycles = 0;

  always @(posedge clk) begin
    int r;
    if (!rst && result_valid === 1'b1 && result_stall == 1'b0)
      sb.check_result(result_beat);
    recv_cycles++;
    if (recv_cycles % 200 == 0) recv_calm = ($urandom_range(0, 3) == 0);
    if (!rst && stall_left == 0 && sb.checked >= next_hold_at) begin
      stall_left = 300;
      next_hold_at += 700;
      hold_offs++;
    end
    if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
      if (!recv_calm) begin
        r = $urandom_range(0, 99);
        if (r < 25) stall_left = $urandom_range(1, 3);
        else if (r < 28) stall_left = $urandom_range(8, 40);
      end
    end
  end

  // Watchdog on total cycles.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results pending", cycle_count, sb.pending());
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    int abort_at;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Items before any start are rejected with merge_done set.
    send_item(beat(OP_WORD, 3'd0, rand_word()));
    send_item(beat(OP_RSVD, 3'd7, '1));

    // Count 0 reads as one run: first word zero, a repeat, then all-ones.
    write_count(4'd0);
    clear_runs();
    run_data[0][0] = 64'd0;
    run_data[0][1] = 64'd0;
    run_data[0][2] = '1;
    run_len[0] = 3;
    send_item(beat(OP_START, 3'd5, '1));
    drive_runs(0, -1);

    // Count 15 clamps to eight runs, all empty: nothing emitted, then done.
    write_count(4'd15);
    clear_runs();
    send_item(beat(OP_START, 3'd0, 64'd0));
    drive_runs(0, -1);
    send_item(beat(OP_END, 3'd3, rand_word()));   // after done: rejected

    // Two runs tied at the first word; wrong run and reserved opcode during
    // loading; a count write mid-merge must not take effect until next start.
    write_count(4'd2);
    clear_runs();
    run_data[0][0] = 64'd5;
    run_data[0][1] = 64'd9;
    run_len[0] = 2;
    run_data[1][0] = 64'd5;
    run_data[1][1] = 64'd7;
    run_len[1] = 2;
    send_item(beat(OP_START, 3'd2, rand_word()));
    send_item(beat(OP_WORD, 3'd1, 64'd5));
    send_item(beat(OP_RSVD, 3'd0, rand_word()));
    write_count(4'd8);
    drive_runs(0, -1);
    merges_done = 3;

    // Random merges: mostly well-formed runs, some noise, some restarts.
    while (useful_items < ITEM_TARGET) begin
      if ($urandom_range(0, 9) < 6) write_count(pick_count());
      fill_runs($urandom_range(0, 2));
      abort_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) : -1;
      send_item(beat(OP_START, 3'($urandom), rand_word()));
      drive_runs(8, abort_at);
      repeat ($urandom_range(0, 2)) send_item(stray_beat());
      merges_done++;
    end

    item_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d merges, %0d item beats (%0d rejected), %0d results checked",
             merges_done, sent_items, sb.errors_seen, sb.checked);
    $display("%0d count writes, %0d long result hold-offs, %0d mismatches",
             config_writes, hold_offs, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
